[hw/rtl/ofsa_pkg.sv]
// Shared types and constants of the oldest-freed slot allocator.
package ofsa_pkg;

  localparam int SLOTS_DEF = 64;

  localparam int ACTIVE_W = 7;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 2;
  localparam int GRANT_W  = 6;
  localparam int SEQ_W    = 32;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 7'd64;

  // register index, taken from paddr[2]
  localparam logic REG_ACTIVE_SLOTS = 1'b0;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic load_en;
    logic scan_en;
    logic commit_en;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

[hw/rtl/ofsa_ctrl.sv]
// Control state machine: clear sweep, accept, table scan and commit.
module ofsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output ofsa_pkg::dp_cmd_t cmd_o,
  input  ofsa_pkg::dp_sts_t sts_i
);

  ofsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ofsa_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ofsa_pkg::S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ofsa_pkg::S_IDLE;
        end
      end
      ofsa_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_en = 1'b1;
          state_d       = ofsa_pkg::S_SCAN;
        end
      end
      ofsa_pkg::S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ofsa_pkg::S_COMMIT;
        end
      end
      ofsa_pkg::S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit_en = 1'b1;
          state_d         = ofsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ofsa_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

[hw/rtl/ofsa_dp.sv]
// Datapath: slot table memories, scan pipeline, counters and result register.
module ofsa_dp #(
  parameter int SLOTS = ofsa_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ofsa_pkg::dp_cmd_t               cmd_i,
  output ofsa_pkg::dp_sts_t               sts_o,
  input  logic                            req_type_i,
  input  logic [ofsa_pkg::IDX_W-1:0]      slot_index_i,
  input  logic [ofsa_pkg::ACTIVE_W-1:0]   active_slots_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [ofsa_pkg::STATUS_W-1:0]   status_o,
  output logic [ofsa_pkg::GRANT_W-1:0]    granted_slot_o,
  output logic [ofsa_pkg::SEQ_W-1:0]      alloc_sequence_o
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = $clog2(SLOTS + 1);
  localparam int XW = (LW > ofsa_pkg::IDX_W) ? LW : ofsa_pkg::IDX_W;

  logic                 alloc_mem [SLOTS];
  logic                 used_mem  [SLOTS];
  logic [31:0]          stamp_mem [SLOTS];

  ofsa_pkg::req_e       req_q;
  logic [ofsa_pkg::IDX_W-1:0] idx_q;
  logic [XW-1:0]        lim_q, lim_d;
  logic [XW-1:0]        addr_q, addr_d;
  logic                 rd_vld_q;
  logic [AW-1:0]        rd_idx_q;
  logic                 alloc_rd_q;
  logic                 used_rd_q;
  logic [31:0]          stamp_rd_q;
  logic                 found_new_q;
  logic                 have_old_q;
  logic [31:0]          best_q;
  logic [AW-1:0]        pick_q;
  logic [ofsa_pkg::SEQ_W-1:0] alloc_cnt_q;
  logic [31:0]          free_cnt_q;
  logic                 out_valid_q;
  ofsa_pkg::status_e    out_status_q;
  logic [ofsa_pkg::GRANT_W-1:0] out_grant_q;
  logic [ofsa_pkg::SEQ_W-1:0]   out_seq_q;

  logic [XW-1:0]        act_x;
  logic [XW-1:0]        idx_x;
  logic [XW-1:0]        pick_x;
  logic                 issue;
  logic                 eval;
  logic                 fresh;
  logic                 older;
  logic                 last;
  logic                 found;
  logic                 free_ok;
  logic                 commit_alloc_ok;
  logic                 commit_free_ok;
  logic                 alloc_we;
  logic [AW-1:0]        alloc_wa;
  logic                 alloc_wd;
  logic                 used_we;
  logic [AW-1:0]        used_wa;

  assign act_x  = XW'(active_slots_i);
  assign lim_d  = (act_x > XW'(SLOTS)) ? XW'(SLOTS) : act_x;
  assign idx_x  = XW'(idx_q);
  assign pick_x = XW'(pick_q);

  assign issue = cmd_i.scan_en && (req_q == ofsa_pkg::REQ_ALLOC) && (addr_q < lim_q);
  assign eval  = cmd_i.scan_en && rd_vld_q && !found_new_q;
  assign fresh = eval && !alloc_rd_q && !used_rd_q;
  assign older = eval && !alloc_rd_q && used_rd_q && (!have_old_q || (stamp_rd_q < best_q));
  assign last  = rd_vld_q && (XW'(rd_idx_q) == (lim_q - XW'(1)));

  assign found   = found_new_q || have_old_q;
  assign free_ok = idx_x < lim_q;

  assign commit_alloc_ok = cmd_i.commit_en && (req_q == ofsa_pkg::REQ_ALLOC) && found;
  assign commit_free_ok  = cmd_i.commit_en && (req_q == ofsa_pkg::REQ_FREE) && free_ok;

  assign sts_o.clr_last  = addr_q == XW'(SLOTS - 1);
  assign sts_o.scan_done = (req_q == ofsa_pkg::REQ_FREE) || (lim_q == '0) ||
                           (rd_vld_q && (fresh || last));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    if (cmd_i.load_en) begin
      addr_d = '0;
    end else if (cmd_i.clr_en || issue) begin
      addr_d = addr_q + XW'(1);
    end else begin
      addr_d = addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      found_new_q <= 1'b0;
      have_old_q  <= 1'b0;
      alloc_cnt_q <= '0;
      free_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      addr_q   <= addr_d;
      rd_vld_q <= issue;
      if (cmd_i.load_en) begin
        found_new_q <= 1'b0;
        have_old_q  <= 1'b0;
      end else begin
        if (fresh) begin
          found_new_q <= 1'b1;
        end
        if (older) begin
          have_old_q <= 1'b1;
        end
      end
      if (commit_alloc_ok) begin
        alloc_cnt_q <= alloc_cnt_q + 32'd1;
      end
      if (commit_free_ok) begin
        free_cnt_q <= free_cnt_q + 32'd1;
      end
      if (cmd_i.commit_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en) begin
      req_q <= ofsa_pkg::req_e'(req_type_i);
      idx_q <= slot_index_i;
      lim_q <= lim_d;
    end
    rd_idx_q <= addr_q[AW-1:0];
    if (fresh || older) begin
      pick_q <= rd_idx_q;
    end
    if (older) begin
      best_q <= stamp_rd_q;
    end
    if (cmd_i.commit_en) begin
      if (req_q == ofsa_pkg::REQ_ALLOC) begin
        out_status_q <= found ? ofsa_pkg::ST_OK : ofsa_pkg::ST_FULL;
        out_grant_q  <= found ? pick_x[ofsa_pkg::GRANT_W-1:0] : '0;
        out_seq_q    <= found ? alloc_cnt_q : '0;
      end else begin
        out_status_q <= free_ok ? ofsa_pkg::ST_OK : ofsa_pkg::ST_BAD_INDEX;
        out_grant_q  <= '0;
        out_seq_q    <= '0;
      end
    end
  end

  assign alloc_we = cmd_i.clr_en || commit_alloc_ok || commit_free_ok;
  assign alloc_wd = commit_alloc_ok;
  assign used_we  = cmd_i.clr_en || commit_alloc_ok;

  always_comb begin
    if (cmd_i.clr_en) begin
      alloc_wa = addr_q[AW-1:0];
      used_wa  = addr_q[AW-1:0];
    end else if (commit_alloc_ok) begin
      alloc_wa = pick_q;
      used_wa  = pick_q;
    end else begin
      alloc_wa = idx_x[AW-1:0];
      used_wa  = pick_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_we) begin
      alloc_mem[alloc_wa] <= alloc_wd;
    end
    if (issue) begin
      alloc_rd_q <= alloc_mem[addr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_wa] <= commit_alloc_ok;
    end
    if (issue) begin
      used_rd_q <= used_mem[addr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_free_ok) begin
      stamp_mem[idx_x[AW-1:0]] <= free_cnt_q;
    end
    if (issue) begin
      stamp_rd_q <= stamp_mem[addr_q[AW-1:0]];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign granted_slot_o   = out_grant_q;
  assign alloc_sequence_o = out_seq_q;

endmodule

[hw/rtl/oldest_freed_slot_allocator_unit.sv]
// Top level of the oldest-freed slot allocator: configuration port, controller and datapath.
// For an allocate transfer the slot table memory is read one entry per cycle from slot 0 up to
// the active limit min(active_slots, SLOTS), stopping early at the first never-used free slot.
// One request is handled at a time; its result waits in an output register while the next
// request is taken, and a held result delays the next commit. After reset a clearing sweep
// runs over the slot table before the first request is accepted.
module oldest_freed_slot_allocator_unit #(
  parameter int SLOTS = ofsa_pkg::SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ofsa_pkg::PADDR_W-1:0]     paddr,
  input  logic [ofsa_pkg::DATA_W-1:0]      pwdata,
  output logic [ofsa_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [ofsa_pkg::IDX_W-1:0]       slot_index_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ofsa_pkg::STATUS_W-1:0]    status_o,
  output logic [ofsa_pkg::GRANT_W-1:0]     granted_slot_o,
  output logic [ofsa_pkg::SEQ_W-1:0]       alloc_sequence_o
);

  logic [ofsa_pkg::ACTIVE_W-1:0] active_q;
  logic                          cfg_wr;
  ofsa_pkg::dp_cmd_t             cmd;
  ofsa_pkg::dp_sts_t             sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == ofsa_pkg::REG_ACTIVE_SLOTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ofsa_pkg::ACTIVE_RST;
    end else if (cfg_wr) begin
      active_q <= pwdata[ofsa_pkg::ACTIVE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ofsa_pkg::REG_ACTIVE_SLOTS) ?
                  ofsa_pkg::DATA_W'(active_q) : '0;

  ofsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ofsa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_type_i),
    .slot_index_i     (slot_index_i),
    .active_slots_i   (active_q),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .granted_slot_o   (granted_slot_o),
    .alloc_sequence_o (alloc_sequence_o)
  );

  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit_en |-> (!out_valid_o || !out_stall_i))
    else $error("result committed over a held transfer");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !out_valid_o) || in_stall_o)
    else $error("request taken while previous one in flight");

  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ofsa_pkg::ST_OK)) |->
      ((granted_slot_o == '0) && (alloc_sequence_o == '0)))
    else $error("failed request carries a grant");

  a_one_step_per_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_en, cmd.load_en, cmd.scan_en, cmd.commit_en}))
    else $error("conflicting datapath commands");

endmodule

[tb/slot_grant_checker.sv]
`timescale 1ns / 100ps
// Slot allocator checker: predicts and compares every result, and checks read data of active_slots.
module slot_grant_checker #(
  parameter int SLOTS = ofsa_pkg::SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ofsa_pkg::PADDR_W-1:0]  paddr,
  input  logic [ofsa_pkg::DATA_W-1:0]   pwdata,
  input  logic [ofsa_pkg::DATA_W-1:0]   prdata,
  input  logic                          pready,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [ofsa_pkg::IDX_W-1:0]    slot_index_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [ofsa_pkg::STATUS_W-1:0] status_o,
  input  logic [ofsa_pkg::GRANT_W-1:0]  granted_slot_o,
  input  logic [ofsa_pkg::SEQ_W-1:0]    alloc_sequence_o,
  output int                            fail_count_o,
  output int                            pending_o
);

  typedef struct packed {
    ofsa_pkg::status_e             status;
    logic [ofsa_pkg::GRANT_W-1:0]  slot;
    logic [ofsa_pkg::SEQ_W-1:0]    seq;
  } grant_t;

  logic                          slot_taken   [SLOTS];
  logic                          slot_touched [SLOTS];
  logic [ofsa_pkg::SEQ_W-1:0]    freed_stamp  [SLOTS];
  logic [ofsa_pkg::SEQ_W-1:0]    next_seq;
  logic [ofsa_pkg::SEQ_W-1:0]    next_stamp;
  logic [ofsa_pkg::ACTIVE_W-1:0] active_cfg;
  grant_t                        grants_due [$];
  grant_t                        seen;
  grant_t                        want;
  int                            n;

  function automatic grant_t predict_grant(ofsa_pkg::req_e kind,
                                           logic [ofsa_pkg::IDX_W-1:0] idx);
    grant_t                     g;
    int                         lim;
    int                         pick;
    bit                         found;
    bit                         have_old;
    logic [ofsa_pkg::SEQ_W-1:0] best;
    g = '{status: ofsa_pkg::ST_OK, slot: '0, seq: '0};
    lim = (int'(active_cfg) > SLOTS) ? SLOTS : int'(active_cfg);
    pick = 0;
    found = 1'b0;
    have_old = 1'b0;
    best = '0;
    if (kind == ofsa_pkg::REQ_ALLOC) begin
      for (int i = 0; i < lim; i++) begin
        if (slot_taken[i]) continue;
        if (!slot_touched[i]) begin
          pick = i;
          found = 1'b1;
          break;
        end
        if (!have_old || freed_stamp[i] < best) begin
          best = freed_stamp[i];
          pick = i;
          have_old = 1'b1;
        end
      end
      if (found || have_old) begin
        slot_taken[pick] = 1'b1;
        slot_touched[pick] = 1'b1;
        g.slot = ofsa_pkg::GRANT_W'(pick);
        g.seq = next_seq;
        next_seq = next_seq + 1;
      end else begin
        g.status = ofsa_pkg::ST_FULL;
      end
    end else if (int'(idx) < lim) begin
      slot_taken[int'(idx)] = 1'b0;
      freed_stamp[int'(idx)] = next_stamp;
      next_stamp = next_stamp + 1;
    end else begin
      g.status = ofsa_pkg::ST_BAD_INDEX;
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (n = 0; n < SLOTS; n++) begin
        slot_taken[n] = 1'b0;
        slot_touched[n] = 1'b0;
        freed_stamp[n] = '0;
      end
      next_seq = '0;
      next_stamp = '0;
      active_cfg = ofsa_pkg::ACTIVE_RST;
      grants_due.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pready && !pwrite &&
          prdata !== ofsa_pkg::DATA_W'(active_cfg)) begin
        $error("active_slots: expected %0d, got %0d", active_cfg, prdata);
        fail_count_o++;
      end
      if (psel && penable && pready && pwrite && paddr[2] == ofsa_pkg::REG_ACTIVE_SLOTS) begin
        active_cfg = pwdata[ofsa_pkg::ACTIVE_W-1:0];
      end
      if (in_valid_i && !in_stall_o) begin
        grants_due.push_back(predict_grant(ofsa_pkg::req_e'(req_type_i), slot_index_i));
      end
      if (out_valid_o && !out_stall_i) begin
        seen = '{status: ofsa_pkg::status_e'(status_o), slot: granted_slot_o,
                 seq: alloc_sequence_o};
        if (grants_due.size() == 0) begin
          $error("result with none expected: status %0d, granted_slot %0d, alloc_sequence %0d",
                 status_o, granted_slot_o, alloc_sequence_o);
          fail_count_o++;
        end else begin
          want = grants_due.pop_front();
          if (seen.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, seen.status);
            fail_count_o++;
          end
          if (seen.slot !== want.slot) begin
            $error("granted_slot: expected %0d, got %0d", want.slot, seen.slot);
            fail_count_o++;
          end
          if (seen.seq !== want.seq) begin
            $error("alloc_sequence: expected %0d, got %0d", want.seq, seen.seq);
            fail_count_o++;
          end
        end
      end
      pending_o = grants_due.size();
    end
  end

endmodule

[tb/tb_oldest_freed_slot_allocator_unit.sv]
`timescale 1ns / 100ps
// Testbench top of the slot allocator: clock, reset, request and register stimulus, verdict.
module tb_oldest_freed_slot_allocator_unit;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 14;
  localparam int PER_PHASE  = 125;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ofsa_pkg::PADDR_W-1:0]  paddr;
  logic [ofsa_pkg::DATA_W-1:0]   pwdata;
  logic [ofsa_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          req_type_i;
  logic [ofsa_pkg::IDX_W-1:0]    slot_index_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [ofsa_pkg::STATUS_W-1:0] status_o;
  logic [ofsa_pkg::GRANT_W-1:0]  granted_slot_o;
  logic [ofsa_pkg::SEQ_W-1:0]    alloc_sequence_o;

  int fails;
  int pending;
  int idle_cycles = 0;
  bit steady = 1'b0;
  int active_lim = ofsa_pkg::SLOTS_DEF;
  int settings [PHASES] = '{2, 64, 1, 5, 0, 9, 127, 3, 16, 65, 32, 4, 64, 7};
  int alloc_weight;
  int pick;

  oldest_freed_slot_allocator_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .slot_index_i     (slot_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .granted_slot_o   (granted_slot_o),
    .alloc_sequence_o (alloc_sequence_o)
  );

  slot_grant_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .slot_index_i     (slot_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .granted_slot_o   (granted_slot_o),
    .alloc_sequence_o (alloc_sequence_o),
    .fail_count_o     (fails),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic send(input ofsa_pkg::req_e kind, input logic [ofsa_pkg::IDX_W-1:0] idx);
    int gap;
    gap = steady ? 0 : $urandom_range(3, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    slot_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic grab();
    send(ofsa_pkg::REQ_ALLOC, ofsa_pkg::IDX_W'($urandom_range(255, 0)));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // write active_slots, then read it back
  task automatic set_active(input int count);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ofsa_pkg::REG_ACTIVE_SLOTS, 2'b00};
    pwdata  <= ofsa_pkg::DATA_W'(count);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    active_lim = (count > ofsa_pkg::SLOTS_DEF) ? ofsa_pkg::SLOTS_DEF : count;
  endtask

  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!steady && $urandom_range(3, 0) != 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(3, 1)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid_i   <= 1'b0;
    req_type_i   <= ofsa_pkg::REQ_ALLOC;
    slot_index_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: full table after reset
    grab();
    grab();
    send(ofsa_pkg::REQ_FREE, 8'd255);
    send(ofsa_pkg::REQ_FREE, 8'd64);
    send(ofsa_pkg::REQ_FREE, 8'd63);
    send(ofsa_pkg::REQ_FREE, 8'd0);
    grab();
    send(ofsa_pkg::REQ_FREE, 8'd1);
    send(ofsa_pkg::REQ_FREE, 8'd170);
    send(ofsa_pkg::REQ_FREE, 8'd85);

    // directed: small tables, oldest freed reuse and exhaustion
    set_active(3);
    grab();
    grab();
    grab();
    send(ofsa_pkg::REQ_FREE, 8'd3);
    send(ofsa_pkg::REQ_FREE, 8'd2);
    send(ofsa_pkg::REQ_FREE, 8'd0);
    grab();
    set_active(1);
    grab();
    grab();
    send(ofsa_pkg::REQ_FREE, 8'd1);
    set_active(0);
    grab();
    send(ofsa_pkg::REQ_FREE, 8'd0);
    set_active(127);
    grab();
    send(ofsa_pkg::REQ_FREE, 8'd63);
    send(ofsa_pkg::REQ_FREE, 8'd127);
    set_active(65);
    grab();

    settings[PHASES-2] = $urandom_range(64, 1);
    settings[PHASES-1] = $urandom_range(127, 0);
    for (int p = 0; p < PHASES; p++) begin
      set_active(settings[p]);
      alloc_weight = $urandom_range(7, 3);
      for (int k = 0; k < PER_PHASE; k++) begin
        if (k % 40 == 0) steady = ($urandom_range(3, 0) == 0);
        pick = $urandom_range(9, 0);
        if (pick < alloc_weight) begin
          grab();
        end else if (pick < 9 && active_lim > 0) begin
          send(ofsa_pkg::REQ_FREE, ofsa_pkg::IDX_W'($urandom_range(active_lim - 1, 0)));
        end else begin
          send(ofsa_pkg::REQ_FREE, ofsa_pkg::IDX_W'($urandom_range(255, 0)));
        end
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ofsa_pkg.sv
hw/rtl/ofsa_ctrl.sv
hw/rtl/ofsa_dp.sv
hw/rtl/oldest_freed_slot_allocator_unit.sv
tb/slot_grant_checker.sv
tb/tb_oldest_freed_slot_allocator_unit.sv
